[src/vfrb_pkg.sv]
// shared types, codes and defaults of the voice frame reorder buffer
// no dependencies; used by vfrb_out_queue and voice_frame_reorder_buffer
package vfrb_pkg;

    // default table depth
    localparam int TABLE_SLOTS_DEF = 32;

    // request actions
    localparam logic [1:0] ACT_ARRIVE = 2'd0;
    localparam logic [1:0] ACT_TICK   = 2'd1;
    localparam logic [1:0] ACT_FLUSH  = 2'd2;
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    // result kinds
    localparam logic KIND_FRAME   = 1'b0;
    localparam logic KIND_SILENCE = 1'b1;

    // register indexes
    localparam logic [2:0] REG_OUTPUT_EN   = 3'd0;
    localparam logic [2:0] REG_SILENCE_EN  = 3'd1;
    localparam logic [2:0] REG_CAPACITY    = 3'd2;
    localparam logic [2:0] REG_PRESSURE    = 3'd3;
    localparam logic [2:0] REG_GAP_LIMIT   = 3'd4;
    localparam logic [2:0] REG_SKIP_LIMIT  = 3'd5;

    // register reset values
    localparam logic [5:0]  CAPACITY_RST  = 6'd32;
    localparam logic [5:0]  PRESSURE_RST  = 6'd16;
    localparam logic [15:0] GAP_LIMIT_RST = 16'd10;
    localparam logic [15:0] SKIP_LIMIT_RST = 16'd5;

    // one result record before the running totals are attached
    typedef struct packed {
        logic        kind;
        logic [31:0] seq;
        logic [63:0] timestamp;
        logic [15:0] handle;
        logic [31:0] count;
    } res_rec_t;

    // control from the sequencer to the result queue
    typedef struct packed {
        logic        push;
        logic        start;
        logic [31:0] lost_total;
        logic [31:0] received_total;
    } q_ctrl_t;

    function automatic res_rec_t mk_frame(input logic [31:0] seq, input logic [63:0] ts,
                                          input logic [15:0] handle);
        res_rec_t r;
        r.kind      = KIND_FRAME;
        r.seq       = seq;
        r.timestamp = ts;
        r.handle    = handle;
        r.count     = 32'd0;
        return r;
    endfunction

    function automatic res_rec_t mk_silence(input logic [31:0] seq, input logic [31:0] cnt);
        res_rec_t r;
        r.kind      = KIND_SILENCE;
        r.seq       = seq;
        r.timestamp = 64'd0;
        r.handle    = 16'd0;
        r.count     = cnt;
        return r;
    endfunction

endpackage

[src/vfrb_out_queue.sv]
// result queue: collects the results of one request, then delivers them
// with the final running totals; uses vfrb_pkg
module vfrb_out_queue #(
    parameter int DEPTH = 2 * vfrb_pkg::TABLE_SLOTS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  vfrb_pkg::q_ctrl_t  ctrl,
    input  vfrb_pkg::res_rec_t rec,
    output logic               busy,
    output logic               m_tvalid,
    input  logic               m_tready,
    // out_seq, out_timestamp, out_handle, silence_count, lost_total, received_total
    output logic [207:0]       m_tdata,
    // kind
    output logic [0:0]         m_tuser,
    output logic               m_tlast
);

    localparam int QAW = $clog2(DEPTH);
    localparam int QCW = $clog2(DEPTH + 1);

    typedef enum logic [1:0] {Q_IDLE, Q_RD, Q_LD, Q_OUT} q_state_t;

    q_state_t           state_reg, state_next;
    logic [QCW-1:0]     cnt_reg, cnt_next;
    logic [QCW-1:0]     rd_reg, rd_next;
    logic [31:0]        lost_reg, lost_next;
    logic [31:0]        recv_reg, recv_next;
    logic               valid_reg, valid_next;
    logic               last_reg, last_next;
    vfrb_pkg::res_rec_t out_reg, out_next;

    vfrb_pkg::res_rec_t res_mem [DEPTH];
    vfrb_pkg::res_rec_t mem_q;
    logic               mem_re;

    // result memory
    always_ff @(posedge clk)
    begin
        if (ctrl.push && state_reg == Q_IDLE)
        begin
            res_mem[cnt_reg[QAW-1:0]] <= rec;
        end
        if (mem_re)
        begin
            mem_q <= res_mem[rd_reg[QAW-1:0]];
        end
    end

    // drain sequencer
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        rd_next    = rd_reg;
        lost_next  = lost_reg;
        recv_next  = recv_reg;
        valid_next = valid_reg;
        last_next  = last_reg;
        out_next   = out_reg;
        mem_re     = 1'b0;
        unique case (state_reg)
            Q_IDLE:
            begin
                if (ctrl.push)
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
                if (ctrl.start && cnt_reg != '0)
                begin
                    lost_next  = ctrl.lost_total;
                    recv_next  = ctrl.received_total;
                    rd_next    = '0;
                    state_next = Q_RD;
                end
            end
            Q_RD:
            begin
                mem_re     = 1'b1;
                state_next = Q_LD;
            end
            Q_LD:
            begin
                out_next   = mem_q;
                last_next  = (rd_reg == cnt_reg - 1'b1);
                valid_next = 1'b1;
                state_next = Q_OUT;
            end
            Q_OUT:
            begin
                if (m_tready)
                begin
                    valid_next = 1'b0;
                    if (last_reg)
                    begin
                        cnt_next   = '0;
                        state_next = Q_IDLE;
                    end
                    else
                    begin
                        rd_next    = rd_reg + 1'b1;
                        state_next = Q_RD;
                    end
                end
            end
            default:
            begin
                state_next = Q_IDLE;
            end
        endcase
    end

    // state and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= Q_IDLE;
            cnt_reg   <= '0;
            rd_reg    <= '0;
            valid_reg <= 1'b0;
            last_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            rd_reg    <= rd_next;
            valid_reg <= valid_next;
            last_reg  <= last_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        lost_reg <= lost_next;
        recv_reg <= recv_next;
        out_reg  <= out_next;
    end

    assign busy     = (state_reg != Q_IDLE);
    assign m_tvalid = valid_reg;
    assign m_tlast  = last_reg;
    assign m_tuser  = out_reg.kind;
    assign m_tdata  = {recv_reg, lost_reg, out_reg.count, out_reg.handle,
                       out_reg.timestamp, out_reg.seq};

endmodule

[src/voice_frame_reorder_buffer.sv]
// voice frame reorder buffer: one request at a time; the table is walked one entry
// at a time in scan, shift and flush, through a registered slot memory read
// results are queued, then delivered one by one once the request is done
// a new request is taken only after the last result of the previous one leaves
// reset clears state machine, fill count, counters and config registers; the slot
// memory and request payload stay; entries beyond the fill count are never read
module voice_frame_reorder_buffer #(
    parameter int TABLE_SLOTS = vfrb_pkg::TABLE_SLOTS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_wr_en,
    input  logic [2:0]   cfg_index,
    input  logic [15:0]  cfg_data,
    input  logic         s_tvalid,
    output logic         s_tready,
    // seq, timestamp, payload_handle, pcm_length
    input  logic [127:0] s_tdata,
    // action
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // out_seq, out_timestamp, out_handle, silence_count, lost_total, received_total
    output logic [207:0] m_tdata,
    // kind
    output logic [0:0]   m_tuser,
    output logic         m_tlast
);

    localparam int AW = $clog2(TABLE_SLOTS);
    localparam int CW = $clog2(TABLE_SLOTS + 1);
    localparam logic [AW-1:0] HEAD_MAX = AW'(TABLE_SLOTS - 1);
    localparam logic [5:0]    SLOTS6   = 6'(TABLE_SLOTS);

    typedef struct packed {
        logic [31:0] seq;
        logic [63:0] timestamp;
        logic [15:0] handle;
    } entry_t;

    typedef enum logic [4:0] {
        ST_IDLE, ST_DISPATCH, ST_PUSH_FRAME, ST_SCAN_RD, ST_SCAN_CHK, ST_INSERT,
        ST_SHIFT_RD, ST_SHIFT_WR, ST_SETTLE_RD, ST_SETTLE_CHK, ST_TICK_RD,
        ST_TICK_CHK, ST_FLUSH_RD, ST_FLUSH_CHK, ST_FLUSH_FRM, ST_DONE, ST_DRAIN
    } state_t;

    // configuration registers
    logic        oen_reg, sen_reg;
    logic [5:0]  capacity_reg, pressure_reg;
    logic [15:0] gap_limit_reg, skip_limit_reg;

    // control state
    state_t         state_reg, state_next;
    logic [31:0]    ne_reg, ne_next;
    logic [AW-1:0]  head_reg, head_next;
    logic [CW-1:0]  fill_reg, fill_next;
    logic [CW-1:0]  idx_reg, idx_next;
    logic [CW-1:0]  pos_reg, pos_next;
    logic           evict_reg, evict_next;
    logic [31:0]    lost_reg, lost_next;
    logic [31:0]    recv_reg, recv_next;
    logic [31:0]    cur_reg, cur_next;

    // latched request
    logic [1:0]  act_reg, act_next;
    logic        pcm_zero_reg, pcm_zero_next;
    entry_t      in_reg, in_next;

    // slot memory port
    entry_t         table_mem [TABLE_SLOTS];
    entry_t         t_q;
    logic           t_re, t_we;
    logic [AW-1:0]  t_raddr, t_waddr;
    entry_t         t_wdata;

    vfrb_pkg::q_ctrl_t  q_ctrl;
    vfrb_pkg::res_rec_t q_rec;
    logic               q_busy;

    logic [5:0]  cap_eff;
    logic [31:0] gap;
    logic [31:0] head_gap;
    logic [31:0] hole;

    // logical slot to physical address around the ring
    function automatic logic [AW-1:0] phys(input logic [AW-1:0] head, input logic [CW-1:0] l);
        logic [CW:0] s;
        s = (CW + 1)'(head) + (CW + 1)'(l);
        if (s >= (CW + 1)'(TABLE_SLOTS))
        begin
            s = s - (CW + 1)'(TABLE_SLOTS);
        end
        return s[AW-1:0];
    endfunction

    function automatic logic [AW-1:0] head_inc(input logic [AW-1:0] head);
        return (head == HEAD_MAX) ? '0 : head + 1'b1;
    endfunction

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oen_reg        <= 1'b0;
            sen_reg        <= 1'b0;
            capacity_reg   <= vfrb_pkg::CAPACITY_RST;
            pressure_reg   <= vfrb_pkg::PRESSURE_RST;
            gap_limit_reg  <= vfrb_pkg::GAP_LIMIT_RST;
            skip_limit_reg <= vfrb_pkg::SKIP_LIMIT_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                vfrb_pkg::REG_OUTPUT_EN:  oen_reg        <= cfg_data[0];
                vfrb_pkg::REG_SILENCE_EN: sen_reg        <= cfg_data[0];
                vfrb_pkg::REG_CAPACITY:   capacity_reg   <= cfg_data[5:0];
                vfrb_pkg::REG_PRESSURE:   pressure_reg   <= cfg_data[5:0];
                vfrb_pkg::REG_GAP_LIMIT:  gap_limit_reg  <= cfg_data;
                vfrb_pkg::REG_SKIP_LIMIT: skip_limit_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // capacity clamped to the range 1 to the table depth
    always_comb
    begin
        if (capacity_reg == 6'd0)
        begin
            cap_eff = 6'd1;
        end
        else if (capacity_reg > SLOTS6)
        begin
            cap_eff = SLOTS6;
        end
        else
        begin
            cap_eff = capacity_reg;
        end
    end

    assign gap      = in_reg.seq - ne_reg;
    assign head_gap = t_q.seq - ne_reg;
    assign hole     = t_q.seq - cur_reg;

    // slot memory, one read and one write port
    always_ff @(posedge clk)
    begin
        if (t_we)
        begin
            table_mem[t_waddr] <= t_wdata;
        end
        if (t_re)
        begin
            t_q <= table_mem[t_raddr];
        end
    end

    // request sequencer
    always_comb
    begin
        state_next    = state_reg;
        ne_next       = ne_reg;
        head_next     = head_reg;
        fill_next     = fill_reg;
        idx_next      = idx_reg;
        pos_next      = pos_reg;
        evict_next    = evict_reg;
        lost_next     = lost_reg;
        recv_next     = recv_reg;
        cur_next      = cur_reg;
        act_next      = act_reg;
        pcm_zero_next = pcm_zero_reg;
        in_next       = in_reg;
        t_re          = 1'b0;
        t_raddr       = phys(head_reg, idx_reg);
        t_we          = 1'b0;
        t_waddr       = phys(head_reg, idx_reg);
        t_wdata       = in_reg;
        q_ctrl.push           = 1'b0;
        q_ctrl.start          = 1'b0;
        q_ctrl.lost_total     = lost_reg;
        q_ctrl.received_total = recv_reg;
        q_rec                 = vfrb_pkg::mk_frame(in_reg.seq, in_reg.timestamp, in_reg.handle);

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    act_next         = s_tuser;
                    in_next.seq       = s_tdata[31:0];
                    in_next.timestamp = s_tdata[95:32];
                    in_next.handle    = s_tdata[111:96];
                    pcm_zero_next    = (s_tdata[127:112] == 16'd0);
                    if (!oen_reg)
                    begin
                        // output disabled: a flush still empties the table
                        if (s_tuser == vfrb_pkg::ACT_FLUSH)
                        begin
                            fill_next = '0;
                        end
                    end
                    else
                    begin
                        state_next = ST_DISPATCH;
                    end
                end
            end
            ST_DISPATCH:
            begin
                case (act_reg)
                    vfrb_pkg::ACT_ARRIVE:
                    begin
                        if (pcm_zero_reg)
                        begin
                            state_next = ST_IDLE;
                        end
                        else
                        begin
                            recv_next = recv_reg + 32'd1;
                            if (in_reg.seq == ne_reg)
                            begin
                                q_ctrl.push = 1'b1;
                                ne_next     = ne_reg + 32'd1;
                                state_next  = ST_SETTLE_RD;
                            end
                            else if (in_reg.seq > ne_reg)
                            begin
                                if (gap >= {16'd0, gap_limit_reg} &&
                                    6'(fill_reg) >= pressure_reg && sen_reg)
                                begin
                                    // large gap under pressure: skip it with silence
                                    q_ctrl.push = 1'b1;
                                    q_rec       = vfrb_pkg::mk_silence(ne_reg, gap);
                                    lost_next   = lost_reg + gap;
                                    state_next  = ST_PUSH_FRAME;
                                end
                                else
                                begin
                                    idx_next   = '0;
                                    state_next = ST_SCAN_RD;
                                end
                            end
                            else
                            begin
                                state_next = ST_DONE;
                            end
                        end
                    end
                    vfrb_pkg::ACT_TICK:
                    begin
                        state_next = (fill_reg != '0) ? ST_TICK_RD : ST_DONE;
                    end
                    vfrb_pkg::ACT_FLUSH:
                    begin
                        idx_next   = '0;
                        cur_next   = ne_reg;
                        state_next = ST_FLUSH_RD;
                    end
                    default:
                    begin
                        state_next = ST_DONE;
                    end
                endcase
            end
            ST_PUSH_FRAME:
            begin
                q_ctrl.push = 1'b1;
                ne_next     = in_reg.seq + 32'd1;
                state_next  = ST_SETTLE_RD;
            end
            // walk the table for a duplicate or the insertion point
            ST_SCAN_RD:
            begin
                if (idx_reg == fill_reg)
                begin
                    pos_next   = fill_reg;
                    state_next = ST_INSERT;
                end
                else
                begin
                    t_re       = 1'b1;
                    state_next = ST_SCAN_CHK;
                end
            end
            ST_SCAN_CHK:
            begin
                if (t_q.seq == in_reg.seq)
                begin
                    t_we       = 1'b1;
                    state_next = ST_DONE;
                end
                else if (t_q.seq > in_reg.seq)
                begin
                    pos_next   = idx_reg;
                    state_next = ST_INSERT;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = ST_SCAN_RD;
                end
            end
            // evict the oldest entry when the fill count has reached the capacity
            ST_INSERT:
            begin
                if (6'(fill_reg) < cap_eff)
                begin
                    evict_next = 1'b0;
                    idx_next   = fill_reg;
                end
                else
                begin
                    evict_next = 1'b1;
                    head_next  = head_inc(head_reg);
                    fill_next  = fill_reg - 1'b1;
                    idx_next   = fill_reg - 1'b1;
                    pos_next   = (pos_reg == '0) ? '0 : pos_reg - 1'b1;
                end
                state_next = ST_SHIFT_RD;
            end
            // move later entries up one slot, then place the new frame
            ST_SHIFT_RD:
            begin
                if (idx_reg == pos_reg)
                begin
                    t_we      = 1'b1;
                    t_waddr   = phys(head_reg, pos_reg);
                    fill_next = fill_reg + 1'b1;
                    if (evict_reg && sen_reg)
                    begin
                        q_ctrl.push = 1'b1;
                        q_rec       = vfrb_pkg::mk_silence(ne_reg, 32'd1);
                        lost_next   = lost_reg + 32'd1;
                        ne_next     = ne_reg + 32'd1;
                        state_next  = ST_SETTLE_RD;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
                else
                begin
                    t_re       = 1'b1;
                    t_raddr    = phys(head_reg, idx_reg - 1'b1);
                    state_next = ST_SHIFT_WR;
                end
            end
            ST_SHIFT_WR:
            begin
                t_we       = 1'b1;
                t_wdata    = t_q;
                idx_next   = idx_reg - 1'b1;
                state_next = ST_SHIFT_RD;
            end
            // drop stale head entries and emit the consecutive run
            ST_SETTLE_RD:
            begin
                if (fill_reg == '0)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    t_re       = 1'b1;
                    t_raddr    = head_reg;
                    state_next = ST_SETTLE_CHK;
                end
            end
            ST_SETTLE_CHK:
            begin
                if (t_q.seq < ne_reg)
                begin
                    head_next  = head_inc(head_reg);
                    fill_next  = fill_reg - 1'b1;
                    state_next = ST_SETTLE_RD;
                end
                else if (t_q.seq == ne_reg)
                begin
                    q_ctrl.push = 1'b1;
                    q_rec       = vfrb_pkg::mk_frame(t_q.seq, t_q.timestamp, t_q.handle);
                    head_next   = head_inc(head_reg);
                    fill_next   = fill_reg - 1'b1;
                    ne_next     = ne_reg + 32'd1;
                    state_next  = ST_SETTLE_RD;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            // idle tick: skip a long gap before the oldest entry
            ST_TICK_RD:
            begin
                t_re       = 1'b1;
                t_raddr    = head_reg;
                state_next = ST_TICK_CHK;
            end
            ST_TICK_CHK:
            begin
                if (t_q.seq > ne_reg && head_gap >= {16'd0, skip_limit_reg} && sen_reg)
                begin
                    q_ctrl.push = 1'b1;
                    q_rec       = vfrb_pkg::mk_silence(ne_reg, head_gap);
                    lost_next   = lost_reg + head_gap;
                    ne_next     = t_q.seq;
                    state_next  = ST_SETTLE_RD;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            // flush: every entry in order, holes filled with silence if enabled
            ST_FLUSH_RD:
            begin
                if (idx_reg == fill_reg)
                begin
                    ne_next    = cur_reg;
                    fill_next  = '0;
                    state_next = ST_DONE;
                end
                else
                begin
                    t_re       = 1'b1;
                    state_next = ST_FLUSH_CHK;
                end
            end
            ST_FLUSH_CHK:
            begin
                if (cur_reg < t_q.seq && sen_reg)
                begin
                    q_ctrl.push = 1'b1;
                    q_rec       = vfrb_pkg::mk_silence(cur_reg, hole);
                    lost_next   = lost_reg + hole;
                end
                state_next = ST_FLUSH_FRM;
            end
            ST_FLUSH_FRM:
            begin
                q_ctrl.push = 1'b1;
                q_rec       = vfrb_pkg::mk_frame(t_q.seq, t_q.timestamp, t_q.handle);
                cur_next    = t_q.seq + 32'd1;
                idx_next    = idx_reg + 1'b1;
                state_next  = ST_FLUSH_RD;
            end
            ST_DONE:
            begin
                q_ctrl.start = 1'b1;
                state_next   = ST_DRAIN;
            end
            ST_DRAIN:
            begin
                if (!q_busy)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ne_reg    <= '0;
            head_reg  <= '0;
            fill_reg  <= '0;
            idx_reg   <= '0;
            pos_reg   <= '0;
            evict_reg <= 1'b0;
            lost_reg  <= '0;
            recv_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            ne_reg    <= ne_next;
            head_reg  <= head_next;
            fill_reg  <= fill_next;
            idx_reg   <= idx_next;
            pos_reg   <= pos_next;
            evict_reg <= evict_next;
            lost_reg  <= lost_next;
            recv_reg  <= recv_next;
        end
    end

    // request payload and flush cursor
    always_ff @(posedge clk)
    begin
        act_reg      <= act_next;
        pcm_zero_reg <= pcm_zero_next;
        in_reg       <= in_next;
        cur_reg      <= cur_next;
    end

    assign s_tready = (state_reg == ST_IDLE);

    vfrb_out_queue #(
        .DEPTH(2 * TABLE_SLOTS)
    ) u_out_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (q_ctrl),
        .rec      (q_rec),
        .busy     (q_busy),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule
